[design/dht_pkg.sv]
package dht_pkg;
	localparam int CAPACITY_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;
	localparam int KEY_W          = 31;
	localparam int SIZE_W         = 6;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd19;

	typedef enum logic [1:0] {
		OP_SEARCH = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_ABSENT  = 2'd1,
		ST_FULL    = 2'd2,
		ST_UNUSED  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		TAG_EMPTY = 2'd0,
		TAG_USED  = 2'd1,
		TAG_TOMB  = 2'd2,
		TAG_BAD   = 2'd3
	} tag_t;
endpackage

[design/double_hash_table.sv]
// Open-addressing key/value table with double hashing. Each request (search,
// insert, remove) takes one transaction and gives one result. A request other
// than a no-op first computes key mod n and key mod (n-1) on a shared
// one-bit-per-cycle remainder unit, then walks the probe sequence slot by slot
// (memory read, then compare), up to n probes; a no-op goes straight to the
// result. The block takes one request at a time. Removes leave tombstones.
// Slot tags sit in flip-flops cleared by reset; keys and values sit in a
// memory. table_size is saturated to 2..CAPACITY.
module double_hash_table
	import dht_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // opcode[1:0], key[32:2], value_in[64:33]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // hit[0], value_out[32:1], status[34:33]
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int MW = $clog2(CAPACITY + 1);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MOD1 = 7'b0000010,
		S_MOD2 = 7'b0000100,
		S_RD   = 7'b0001000,
		S_CMP  = 7'b0010000,
		S_ACT  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	state_t state_q;
	logic [SIZE_W-1:0] size_q;
	logic [MW-1:0] n_q, pos_q, stride_q, i_q, found_at_q, free_at_q;
	logic found_q, free_q;
	op_t op_q;
	logic [KEY_W-1:0] key_q;
	logic [VALUE_BITS-1:0] val_q;
	tag_t tag_q [CAPACITY];
	logic [KEY_W-1:0] mkey [CAPACITY];
	logic [VALUE_BITS-1:0] mval [CAPACITY];
	logic [KEY_W-1:0] rkey_q;
	logic [VALUE_BITS-1:0] rval_q;
	logic hit_q;
	logic [31:0] vout_q;
	status_t st_q;

	logic mod_start, mod_done;
	logic [MW-1:0] mod_div, mod_rem;
	logic [MW:0] nxt;
	logic [AW-1:0] pa;
	logic [AW-1:0] wa;
	logic [MW-1:0] nsat;

	assign nsat = (size_q < 6'd2) ? MW'(2) :
		((32'(size_q) > CAPACITY) ? MW'(CAPACITY) : MW'(size_q));
	assign pa = pos_q[AW-1:0];
	assign mod_div = (state_q == S_MOD1) ? n_q : MW'(n_q - 1'b1);

	dht_mod #(.MW(MW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .dividend(key_q),
		.divisor(mod_div), .done(mod_done), .remainder(mod_rem)
	);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = {5'd0, st_q, vout_q, hit_q};
	assign nxt = {1'b0, pos_q} + {1'b0, stride_q};
	assign wa = found_q ? found_at_q[AW-1:0] : free_at_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (state_q == S_RD) begin
			rkey_q <= mkey[pa];
			rval_q <= mval[pa];
		end
		if (state_q == S_ACT && op_q == OP_INSERT && (found_q || free_q)) begin
			mval[wa] <= val_q;
			if (!found_q) mkey[wa] <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			size_q  <= SIZE_RESET;
			mod_start <= 1'b0;
			for (int k = 0; k < CAPACITY; k++) tag_q[k] <= TAG_EMPTY;
		end else begin
			mod_start <= 1'b0;
			if (cfg_we) size_q <= cfg_wdata;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q  <= op_t'(s_tdata[1:0]);
						key_q <= s_tdata[32:2];
						val_q <= VALUE_BITS'(s_tdata[64:33]);
						n_q   <= nsat;
						found_q <= 1'b0;
						free_q  <= 1'b0;
						i_q     <= '0;
						hit_q <= 1'b0;
						vout_q <= '0;
						st_q <= ST_DONE;
						if (op_t'(s_tdata[1:0]) == OP_NOP) begin
							state_q <= S_OUT;
						end else begin
							mod_start <= 1'b1;
							state_q <= S_MOD1;
						end
					end
				end
				S_MOD1: if (mod_done) begin
					pos_q <= mod_rem;
					mod_start <= 1'b1;
					state_q <= S_MOD2;
				end
				S_MOD2: if (mod_done) begin
					stride_q <= MW'(mod_rem + 1'b1);
					state_q <= S_RD;
				end
				S_RD: state_q <= S_CMP;
				S_CMP: begin
					state_q <= S_RD;
					if (tag_q[pa] == TAG_EMPTY) begin
						if (!free_q) begin
							free_q <= 1'b1;
							free_at_q <= pos_q;
						end
						state_q <= S_ACT;
					end else if (tag_q[pa] == TAG_USED) begin
						if (rkey_q == key_q) begin
							found_q <= 1'b1;
							found_at_q <= pos_q;
							state_q <= S_ACT;
						end
					end else if (!free_q) begin
						free_q <= 1'b1;
						free_at_q <= pos_q;
					end
					pos_q <= (nxt >= {1'b0, n_q}) ? MW'(nxt - {1'b0, n_q}) : nxt[MW-1:0];
					i_q <= MW'(i_q + 1'b1);
					if (MW'(i_q + 1'b1) == n_q) state_q <= S_ACT;
				end
				S_ACT: begin
					state_q <= S_OUT;
					priority case (op_q)
						OP_SEARCH: begin
							hit_q <= found_q;
							vout_q <= found_q ? 32'(rval_q) : '0;
							st_q <= found_q ? ST_DONE : ST_ABSENT;
						end
						OP_INSERT: begin
							hit_q <= found_q;
							st_q <= (found_q || free_q) ? ST_DONE : ST_FULL;
							if (!found_q && free_q) tag_q[wa] <= TAG_USED;
						end
						default: begin
							hit_q <= found_q;
							st_q <= found_q ? ST_DONE : ST_ABSENT;
							if (found_q) tag_q[found_at_q[AW-1:0]] <= TAG_TOMB;
						end
					endcase
				end
				S_OUT: if (m_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[design/dht_mod.sv]
// Sequential remainder a mod m, restoring, one bit per cycle.
module dht_mod
	import dht_pkg::*;
#(
	parameter int MW = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KEY_W-1:0]  dividend,
	input  logic [MW-1:0]     divisor,
	output logic              done,
	output logic [MW-1:0]     remainder
);
	localparam int CW = $clog2(KEY_W + 1);

	logic [KEY_W-1:0] sh_q;
	logic [MW:0]      rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [MW+1:0]    trial;

	assign trial = {rem_q, sh_q[KEY_W-1]};
	assign remainder = rem_q[MW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(KEY_W);
				rem_q  <= '0;
				sh_q   <= dividend;
			end else if (busy_q) begin
				if (trial >= {2'b00, divisor}) begin
					rem_q <= (MW+1)'(trial - {2'b00, divisor});
				end else begin
					rem_q <= trial[MW:0];
				end
				sh_q  <= {sh_q[KEY_W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import dht_pkg::*;

	localparam int SLOTS = 32;
	localparam int IDLE_LIMIT = 20000;

	// lowest field last: op sits in the low bits
	typedef struct packed {
		logic [31:0] val;
		logic [30:0] key;
		logic [1:0]  op;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] val;
		logic        hit;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [5:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	double_hash_table u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #1 clk = ~clk;

	// table mirror
	tag_t        mir_tag [SLOTS];
	logic [30:0] mir_key [SLOTS];
	logic [31:0] mir_val [SLOTS];
	logic [5:0]  mir_size;

	request_t pending_reqs[$];
	reply_t   expected_replies[$];
	int       mismatches = 0;
	int       accepted = 0;
	int       replies_seen = 0;
	bit       hold_sender = 0;
	int       long_stall = 0;
	int       idle_cycles = 0;
	int       full_seen = 0;

	function automatic reply_t lookup_apply(request_t r);
		reply_t res;
		int n, pos, stride, found_at, free_at;
		bit found, have_free;
		res = '0;
		found = 0;
		have_free = 0;
		found_at = 0;
		free_at = 0;
		if (op_t'(r.op) == OP_NOP)
			return res;
		n = mir_size;
		if (n < 2) n = 2;
		if (n > SLOTS) n = SLOTS;
		pos = r.key % n;
		stride = 1 + r.key % (n - 1);
		for (int i = 0; i < n; i++) begin
			if (mir_tag[pos] == TAG_EMPTY) begin
				if (!have_free) begin
					have_free = 1;
					free_at = pos;
				end
				break;
			end
			if (mir_tag[pos] == TAG_USED) begin
				if (mir_key[pos] == r.key) begin
					found = 1;
					found_at = pos;
					break;
				end
			end else if (!have_free) begin
				have_free = 1;
				free_at = pos;
			end
			pos = (pos + stride) % n;
		end
		case (op_t'(r.op))
			OP_SEARCH: begin
				res.hit = found;
				res.val = found ? mir_val[found_at] : '0;
				res.status = found ? ST_DONE : ST_ABSENT;
			end
			OP_INSERT: begin
				if (found) begin
					mir_val[found_at] = r.val;
					res.hit = 1'b1;
					res.status = ST_DONE;
				end else if (have_free) begin
					mir_tag[free_at] = TAG_USED;
					mir_key[free_at] = r.key;
					mir_val[free_at] = r.val;
					res.status = ST_DONE;
				end else begin
					res.status = ST_FULL;
				end
			end
			default: begin
				if (found) begin
					mir_tag[found_at] = TAG_TOMB;
					res.hit = 1'b1;
					res.status = ST_DONE;
				end else begin
					res.status = ST_ABSENT;
				end
			end
		endcase
		return res;
	endfunction

	// sender: bursts and gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			expected_replies.push_back(lookup_apply(s_tdata[64:0]));
			accepted <= accepted + 1;
		end
		if (!(s_tvalid && !s_tready)) begin
			if (gap_left > 0 || hold_sender || pending_reqs.size() == 0) begin
				s_tvalid <= 1'b0;
				if (gap_left > 0) gap_left <= gap_left - 1;
			end else begin
				request_t r;
				r = pending_reqs.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {7'b0, r};
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 12);
					if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 150);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver: own stall pattern, plus one long hold-off
	int rx_phase = 0;
	always @(posedge clk) begin
		rx_phase <= rx_phase + 1;
		if (long_stall > 0) begin
			long_stall <= long_stall - 1;
			m_tready <= 1'b0;
		end else if (rx_phase[8]) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			reply_t got, exp;
			got = m_tdata[34:0];
			replies_seen <= replies_seen + 1;
			if (expected_replies.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected reply %h", got);
			end else begin
				exp = expected_replies.pop_front();
				if (exp.status == ST_FULL) full_seen <= full_seen + 1;
				if (got !== exp) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("reply mismatch: exp hit=%0d val=%h st=%0d got hit=%0d val=%h st=%0d",
							exp.hit, exp.val, exp.status, got.hit, got.val, got.status);
				end
			end
		end
	end

	// watchdog on accepted transactions
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	logic [30:0] key_pool[16];

	function automatic request_t make_req(int phase_kind);
		request_t r;
		int k;
		k = $urandom_range(0, 99);
		r.val = $urandom;
		if (k < 85) r.key = key_pool[$urandom_range(0, 15)];
		else r.key = 31'($urandom);
		k = $urandom_range(0, 99);
		if (k < 3) r.op = OP_NOP;
		else if (k < 35 + phase_kind * 15) r.op = OP_INSERT;
		else if (k < 70) r.op = OP_SEARCH;
		else r.op = OP_REMOVE;
		return r;
	endfunction

	// let the queue empty, then hold the sender until every reply is back
	task automatic drain;
		while (pending_reqs.size() != 0)
			@(posedge clk);
		hold_sender = 1;
		while (s_tvalid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		hold_sender = 0;
	endtask

	task automatic set_size(logic [5:0] sz);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= sz;
		mir_size = sz;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push(logic [1:0] op, logic [30:0] key, logic [31:0] val);
		request_t r;
		r.op = op;
		r.key = key;
		r.val = val;
		pending_reqs.push_back(r);
	endtask

	initial begin
		logic [5:0] sizes[8];
		for (int i = 0; i < SLOTS; i++) begin
			mir_tag[i] = TAG_EMPTY;
			mir_key[i] = '0;
			mir_val[i] = '0;
		end
		mir_size = SIZE_RESET;
		hold_sender = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		hold_sender = 0;

		// directed: extremes, every operation, tombstone reuse, nop
		push(OP_SEARCH, 31'h0, 32'hffffffff);
		push(OP_INSERT, 31'h0, 32'hffffffff);
		push(OP_INSERT, 31'h7fffffff, 32'h0);
		push(OP_SEARCH, 31'h0, 32'h0);
		push(OP_SEARCH, 31'h7fffffff, 32'hffffffff);
		push(OP_INSERT, 31'd19, 32'h12345678);
		push(OP_INSERT, 31'd38, 32'h9abcdef0);
		push(OP_REMOVE, 31'd19, 32'h0);
		push(OP_SEARCH, 31'd38, 32'h0);
		push(OP_REMOVE, 31'd19, 32'h0);
		push(OP_INSERT, 31'd57, 32'h55aa55aa);
		push(OP_INSERT, 31'h0, 32'haaaaaaaa);
		push(OP_NOP, 31'h2aaaaaaa, 32'h5555aaaa);
		push(OP_SEARCH, 31'd57, 32'h0);
		push(OP_REMOVE, 31'h7fffffff, 32'h0);
		drain();

		// minimum size: fill up, hit the full case
		set_size(6'd0);
		for (int i = 0; i < 5; i++) push(OP_INSERT, 31'(i * 7 + 1), $urandom);
		push(OP_SEARCH, 31'd8, 32'h0);
		push(OP_REMOVE, 31'd1, 32'h0);
		push(OP_INSERT, 31'd100, 32'hdeadbeef);
		drain();

		sizes = '{6'd2, 6'd3, 6'd32, 6'd63, 6'd7, 6'd19, 6'd31, 6'd1};
		for (int ph = 0; ph < 8; ph++) begin
			set_size(sizes[ph]);
			for (int i = 0; i < 16; i++)
				key_pool[i] = (ph % 2) ? 31'($urandom_range(0, 200)) : 31'($urandom);
			for (int i = 0; i < 128; i++) pending_reqs.push_back(make_req(ph % 3));
			if (ph == 2) begin
				// long receiver hold-off while the sender keeps offering
				wait (accepted > 0);
				long_stall = 3000;
			end
			drain();
		end
		repeat (300) @(posedge clk);
		$display("covered %0d requests, %0d replies, %0d full-table inserts, 9 table sizes",
			accepted, replies_seen, full_seen);
		if (mismatches == 0 && expected_replies.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

[double_hash_table.f]
design/dht_pkg.sv
design/dht_mod.sv
design/double_hash_table.sv
bench/testbench.sv
